[sv/rasb_pkg.sv]
// rasb_pkg: shared types and constants for the saturating add/subtract blend.
// No dependencies; imported by rasb_scale and rgba_add_sub_blend_top.
package rasb_pkg;

   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 4;
   localparam int PIXEL_W   = CHAN_W * NUM_CHAN;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_OP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_DEST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_OPA   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPACITY   = 2'd3;

   // blend_op codes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   localparam logic [CHAN_W-1:0] OPACITY_RESET = 8'hff;
   localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'hff;
   localparam logic [CHAN_W-1:0] CHAN_MIN      = 8'h00;

   typedef struct packed {
      logic              blend_op;
      logic              keep_dest_alpha;
      logic              use_opacity;
      logic [CHAN_W-1:0] opacity;
   } cfg_type;

endpackage : rasb_pkg

[sv/rasb_scale.sv]
// rasb_scale: opacity scaling of the source pixel, one 8x8 multiply per colour byte.
// Depends on rasb_pkg.
module rasb_scale (
   input  rasb_pkg::cfg_type                 cfg,
   input  logic [rasb_pkg::PIXEL_W-1:0]      src_pixel,
   output logic [rasb_pkg::PIXEL_W-1:0]      scaled_pixel
);
   import rasb_pkg::*;

   logic [PIXEL_W-1:0] scaled_w;

   genvar k;
   generate
      for (k = 0; k < NUM_CHAN - 1; k++) begin : g_chan
         logic [CHAN_W-1:0]   s;
         logic [CHAN_W-1:0]   mul_in;
         logic [2*CHAN_W-1:0] prod;
         assign s = src_pixel[k*CHAN_W +: CHAN_W];
         // subtract: 255 - ((255-s)*opa >> 8) is the complement of (~s*opa >> 8)
         assign mul_in = (cfg.blend_op == OP_SUB) ? ~s : s;
         assign prod   = mul_in * cfg.opacity;
         assign scaled_w[k*CHAN_W +: CHAN_W] = (cfg.blend_op == OP_SUB) ?
                                               ~prod[2*CHAN_W-1:CHAN_W] :
                                               prod[2*CHAN_W-1:CHAN_W];
      end
   endgenerate

   // when opacity is on, alpha is forced to 0 for add (neutral) and to 255 for subtract
   assign scaled_w[PIXEL_W-1 -: CHAN_W] = (cfg.blend_op == OP_SUB) ? CHAN_MAX : CHAN_MIN;

   assign scaled_pixel = cfg.use_opacity ? scaled_w : src_pixel;

endmodule : rasb_scale

[sv/rgba_add_sub_blend_top.sv]
// rgba_add_sub_blend_top: three-stage saturating add/subtract pixel blend.
// Depends on rasb_pkg and rasb_scale.
//
//  channel | ports         | beat contents (low bit up)
//  --------+---------------+-----------------------------------------------
//  req     | req_t*        | tdata: dest_pixel[31:0], src_pixel[63:32]; tlast: last_in_run
//  rsp     | rsp_t*        | tdata: blended_pixel[31:0]; tlast: last_out
//  csr     | csr_we/index  | 0 blend_op, 1 keep_dest_alpha, 2 use_opacity, 3 opacity
//
// One pixel per clock sustained while rsp_tready stays high.
// Stage 1 registers the beat, stage 2 holds the opacity-scaled source (one 8x8
// multiply per colour byte), stage 3 is the saturating add/subtract output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stalled rsp side holds every beat in place.
// Synchronous active-high reset empties the pipe and sets opacity to 255.
module rgba_add_sub_blend_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*rasb_pkg::PIXEL_W-1:0]      req_tdata,   // dest_pixel, src_pixel
   input  logic                                req_tlast,   // last_in_run
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rasb_pkg::PIXEL_W-1:0]        rsp_tdata,   // blended_pixel
   output logic                                rsp_tlast,   // last_out
   // configuration
   input  logic                                csr_we,
   input  logic [rasb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rasb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rasb_pkg::*;

   // ---------------- configuration registers ----------------
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLEND_OP:  cfg_in.blend_op        = csr_wdata[0];
            CSR_KEEP_DEST: cfg_in.keep_dest_alpha = csr_wdata[0];
            CSR_USE_OPA:   cfg_in.use_opacity     = csr_wdata[0];
            CSR_OPACITY:   cfg_in.opacity         = csr_wdata[CHAN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_op        <= OP_ADD;
         cfg_ff.keep_dest_alpha <= 1'b0;
         cfg_ff.use_opacity     <= 1'b0;
         cfg_ff.opacity         <= OPACITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ready1, ready2, ready3;

   assign ready3 = !v3_ff || rsp_tready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_tready = ready1;

   assign v1_in = ready1 ? req_tvalid : v1_ff;
   assign v2_in = ready2 ? v1_ff      : v2_ff;
   assign v3_in = ready3 ? v2_ff      : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   logic [PIXEL_W-1:0] dest1_ff, src1_ff;
   logic               last1_ff;

   always_ff @(posedge clock) begin
      if (ready1 && req_tvalid) begin
         dest1_ff <= req_tdata[PIXEL_W-1:0];
         src1_ff  <= req_tdata[2*PIXEL_W-1:PIXEL_W];
         last1_ff <= req_tlast;
      end
   end

   // ---------------- stage 2: scaled source ----------------
   logic [PIXEL_W-1:0] scaled_in;
   logic [PIXEL_W-1:0] dest2_ff, src2_ff;
   logic               last2_ff;

   rasb_scale u_scale (
      .cfg          (cfg_ff),
      .src_pixel    (src1_ff),
      .scaled_pixel (scaled_in)
   );

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         dest2_ff <= dest1_ff;
         src2_ff  <= scaled_in;
         last2_ff <= last1_ff;
      end
   end

   // ---------------- stage 3: saturating add / subtract ----------------
   logic [PIXEL_W-1:0] blend_in;
   logic [PIXEL_W-1:0] out3_ff;
   logic               last3_ff;

   always_comb begin
      logic [CHAN_W:0]   sum;
      logic [CHAN_W:0]   diff;
      logic [CHAN_W-1:0] d;
      logic [CHAN_W-1:0] s;
      blend_in = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         d    = dest2_ff[k*CHAN_W +: CHAN_W];
         s    = src2_ff[k*CHAN_W +: CHAN_W];
         sum  = {1'b0, d} + {1'b0, s};
         diff = {1'b0, d} - {1'b0, s};
         if (cfg_ff.blend_op == OP_SUB) begin
            blend_in[k*CHAN_W +: CHAN_W] = diff[CHAN_W] ? CHAN_MIN : diff[CHAN_W-1:0];
         end else begin
            blend_in[k*CHAN_W +: CHAN_W] = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
         end
      end
      // keep mode: destination alpha goes through untouched
      if (cfg_ff.keep_dest_alpha) begin
         blend_in[PIXEL_W-1 -: CHAN_W] = dest2_ff[PIXEL_W-1 -: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && v2_ff) begin
         out3_ff  <= blend_in;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = out3_ff;
   assign rsp_tlast  = last3_ff;

   // ---------------- assertions ----------------
   // a req beat is only taken when stage 1 can hand its content on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!v1_ff || ready2))
      else $error("stage 1 overwritten while full");

   // a stalled stage 2 keeps its beat
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ready3) |=> v2_ff)
      else $error("stage 2 beat lost during stall");

   // a beat leaving stage 2 always lands in the output register
   a_stage3_fill: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && ready3) |=> v3_ff)
      else $error("beat dropped between stage 2 and output");

endmodule : rgba_add_sub_blend_top
